// ===== rtl/core/signed_int64_alu_top_assert.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the signed 64-bit alu
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT64_ALU_TOP_ASSERT_SVH
`define SIGNED_INT64_ALU_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SIA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/sia_pkg.sv =====
// ---------------------------------------------------------------------------
// sia_pkg
// types and constants shared by the alu front and back ends
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package sia_pkg;
  localparam int unsigned DivSteps = 64;
  localparam int unsigned DivLat = DivSteps + 2;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_OR = 5'd3, OP_XOR = 5'd4,
    OP_AND = 5'd5, OP_SHL = 5'd6, OP_SHR = 5'd7, OP_DIV = 5'd8, OP_MOD = 5'd9,
    OP_LT = 5'd10, OP_GT = 5'd11, OP_EQ = 5'd12, OP_NE = 5'd13, OP_LE = 5'd14,
    OP_GE = 5'd15, OP_LAND = 5'd16, OP_LOR = 5'd17, OP_NEG = 5'd18,
    OP_PLUS = 5'd19, OP_NOT = 5'd20
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIVZERO = 2'd1, ST_BADOP = 2'd2, ST_RSVD = 2'd3
  } status_t;

  // how the back end finishes an item
  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0, K_MUL = 2'd1, K_DIV = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        is_mod;
    logic        neg_res;
    logic [63:0] val;   // finished value for simple ops, multiplicand for multiply, dividend magnitude for divide
    logic [63:0] aux;   // divisor magnitude or multiplier operand
    status_t     st;
  } cmd_t;
endpackage

// ===== rtl/core/sia_front.sv =====
// ---------------------------------------------------------------------------
// sia_front
// decodes an item and evaluates the simple operations combinationally
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_int64_alu_top_assert.svh"
module sia_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [4:0]    op,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output sia_pkg::cmd_t cmd
);
  import sia_pkg::*;
  logic lt_ab, lt_ba;
  logic [63:0] ma, mb;
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);
  assign ma = a[63] ? (64'd0 - a) : a;
  assign mb = b[63] ? (64'd0 - b) : b;

  always_comb begin
    cmd = '{kind: K_SIMPLE, is_mod: 1'b0, neg_res: 1'b0, val: 64'd0, aux: b,
            st: ST_OK};
    unique case (op)
      OP_ADD:  cmd.val = a + b;
      OP_SUB:  cmd.val = a - b;
      OP_MUL: begin
        cmd.kind = K_MUL;
        cmd.val = a;
      end
      OP_OR:   cmd.val = a | b;
      OP_XOR:  cmd.val = a ^ b;
      OP_AND:  cmd.val = a & b;
      OP_SHL:  cmd.val = a << b[5:0];
      OP_SHR:  cmd.val = $unsigned($signed(a) >>> b[5:0]);
      OP_DIV, OP_MOD: begin
        if (b == 64'd0) begin
          cmd.st = ST_DIVZERO;
        end else begin
          cmd.kind = K_DIV;
          cmd.is_mod = (op == OP_MOD);
          cmd.neg_res = (op == OP_MOD) ? a[63] : (a[63] ^ b[63]);
          cmd.val = ma;
          cmd.aux = mb;
        end
      end
      OP_LT:   cmd.val = {63'd0, lt_ab};
      OP_GT:   cmd.val = {63'd0, lt_ba};
      OP_EQ:   cmd.val = {63'd0, a == b};
      OP_NE:   cmd.val = {63'd0, a != b};
      OP_LE:   cmd.val = {63'd0, !lt_ba};
      OP_GE:   cmd.val = {63'd0, !lt_ab};
      OP_LAND: cmd.val = {63'd0, (a != 64'd0) && (b != 64'd0)};
      OP_LOR:  cmd.val = {63'd0, (a != 64'd0) || (b != 64'd0)};
      OP_NEG:  cmd.val = 64'd0 - a;
      OP_PLUS: cmd.val = a;
      OP_NOT:  cmd.val = ~a;
      default: cmd.st = ST_BADOP;
    endcase
  end

  `SIA_ASSERT_IMP(a_badop_zero, clk, rst_n, cmd.st == ST_BADOP, cmd.val == 64'd0)
  `SIA_ASSERT_IMP(a_divz_simple, clk, rst_n, cmd.st == ST_DIVZERO, cmd.kind == K_SIMPLE)
  `SIA_ASSERT_IMP(a_div_nonzero, clk, rst_n, cmd.kind == K_DIV, cmd.aux != 64'd0)
endmodule

// ===== rtl/core/sia_queue.sv =====
// ---------------------------------------------------------------------------
// sia_queue
// two-entry queue between front and back ends
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sia_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sia_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output sia_pkg::cmd_t rd_data
);
  import sia_pkg::*;
  cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_wr, do_rd;
  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end
endmodule

// ===== rtl/core/sia_back.sv =====
// ---------------------------------------------------------------------------
// sia_back
// pipelined back end: multiplier, restoring divider, sign fix and output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "signed_int64_alu_top_assert.svh"
module sia_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sia_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_val,
  output sia_pkg::status_t out_st
);
  import sia_pkg::*;
  localparam int unsigned N = DivLat;

  typedef struct packed {
    kind_t       kind;
    logic        is_mod;
    logic        neg_res;
    logic [63:0] q;     // quotient being built, or value
    logic [63:0] rem;   // partial remainder
    logic [63:0] d;     // divisor or multiplier operand
    status_t     st;
  } stg_t;

  stg_t s_r [N];
  stg_t s_nxt [N];
  logic v_r [N];
  logic adv;
  logic [63:0] mp_lo_r;
  logic [31:0] mp_hl_r;
  logic [31:0] mp_lh_r;
  logic [31:0] mcross;
  assign adv = !v_r[N-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = v_r[N-1];
  assign mcross = mp_hl_r + mp_lh_r;

  // stage 0 registers operands; stages 1..64 each do one divide step,
  // multiply partial products use stages 1 and 2
  always_comb begin
    logic [64:0] tr;
    logic [64:0] df;
    s_nxt[0] = '{kind: in_cmd.kind, is_mod: in_cmd.is_mod, neg_res: in_cmd.neg_res,
                 q: in_cmd.val, rem: 64'd0, d: in_cmd.aux, st: in_cmd.st};
    for (int i = 1; i <= DivSteps; i++) begin
      s_nxt[i] = s_r[i-1];
      tr = {s_r[i-1].rem, s_r[i-1].q[63]};
      df = tr - {1'b0, s_r[i-1].d};
      if (s_r[i-1].kind == K_DIV) begin
        s_nxt[i].q = {s_r[i-1].q[62:0], !df[64]};
        s_nxt[i].rem = df[64] ? tr[63:0] : df[63:0];
      end
    end
    if (s_r[1].kind == K_MUL)
      s_nxt[2].q = {mcross, 32'd0} + mp_lo_r;
    s_nxt[N-1] = s_r[N-2];
    case ({s_r[N-2].kind})
      K_DIV: begin
        s_nxt[N-1].q = s_r[N-2].is_mod
            ? (s_r[N-2].neg_res ? 64'd0 - s_r[N-2].rem : s_r[N-2].rem)
            : (s_r[N-2].neg_res ? 64'd0 - s_r[N-2].q : s_r[N-2].q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N; i++) s_r[i] <= s_nxt[i];
      if (s_r[0].kind == K_MUL) begin
        mp_lo_r <= s_r[0].q[31:0] * s_r[0].d[31:0];
        mp_hl_r <= s_r[0].q[63:32] * s_r[0].d[31:0];
        mp_lh_r <= s_r[0].q[31:0] * s_r[0].d[63:32];
      end
    end
    if (!rst_n) begin
      for (int i = 0; i < N; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < N; i++) v_r[i] <= v_r[i-1];
    end
  end
  assign out_val = s_r[N-1].q;
  assign out_st = s_r[N-1].st;

  `SIA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_val))
  `SIA_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && out_st != ST_OK, out_val == 64'd0)
  `SIA_ASSERT_IMP(a_no_rsvd, clk, rst_n, out_valid, out_st != ST_RSVD)
endmodule

// ===== rtl/core/signed_int64_alu_top.sv =====
// ---------------------------------------------------------------------------
// signed_int64_alu_top
// signed 64-bit integer alu with pipelined multiply and divide
// ---------------------------------------------------------------------------
// one item is taken per cycle while s_axis_tready is high, and every item,
// whatever its opcode, leaves the block in order after passing the decode
// register, the two-entry queue, the operand stage, 64 divide steps of one
// quotient bit each and the sign fix; the 64-stage restoring divider pipeline
// sets the depth, and the multiplier's 32x32 partial products ride inside it
`timescale 1ns / 1ps
module signed_int64_alu_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // req_type[4:0], left[68:5], right[132:69]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // result_value[63:0], status[65:64]
);
  import sia_pkg::*;
  cmd_t fcmd, fcmd_r, qcmd;
  logic fv_r, qv, qr, bready;
  logic [63:0] bval;
  status_t bst;

  sia_front u_front (.clk(clk), .rst_n(rst_n), .op(s_axis_tdata[4:0]),
    .a(s_axis_tdata[68:5]), .b(s_axis_tdata[132:69]), .cmd(fcmd));

  // front register, accepts when it is empty or the queue can take its contents
  assign s_axis_tready = !fv_r || qr;
  always_ff @(posedge clk) begin
    if (s_axis_tready) fcmd_r <= fcmd;
    if (!rst_n) fv_r <= 1'b0;
    else if (s_axis_tready) fv_r <= s_axis_tvalid;
  end

  sia_queue u_queue (.clk(clk), .rst_n(rst_n), .wr_valid(fv_r), .wr_ready(qr),
    .wr_data(fcmd_r), .rd_valid(qv), .rd_ready(bready), .rd_data(qcmd));

  sia_back u_back (.clk(clk), .rst_n(rst_n), .in_valid(qv), .in_ready(bready),
    .in_cmd(qcmd), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_val(bval), .out_st(bst));

  assign m_axis_tdata = {6'd0, bst, bval};
endmodule

// ===== tb/sv/tb_signed_int64_alu_top.sv =====
// ---------------------------------------------------------------------------
// tb_signed_int64_alu_top
// self-checking bench for the signed 64-bit alu: directed corner items, then
// random bursts, with a long sink stall; results checked in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_signed_int64_alu_top;
  import sia_pkg::*;

  localparam int unsigned Latency = 68;
  localparam int unsigned WatchLimit = 20000;
  localparam logic [63:0] MinVal = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] value;
    status_t     st;
  } alu_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;  // req_type[4:0], left[68:5], right[132:69]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;       // result_value[63:0], status[65:64]

  alu_res_t alu_results_q[$];
  int       err_cnt = 0;
  int       idle_cycles = 0;
  bit       hold_sink = 1'b0;
  bit       sink_free = 1'b0;

  signed_int64_alu_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // computes the expected value and status of one operation
  function automatic alu_res_t alu_compute(logic [4:0] op, logic [63:0] a, logic [63:0] b);
    alu_res_t    r;
    logic [63:0] ua;
    logic [63:0] ub;
    r.value = '0;
    r.st = ST_OK;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    case (op)
      OP_ADD:  r.value = a + b;
      OP_SUB:  r.value = a - b;
      OP_MUL:  r.value = a * b;
      OP_OR:   r.value = a | b;
      OP_XOR:  r.value = a ^ b;
      OP_AND:  r.value = a & b;
      OP_SHL:  r.value = a << b[5:0];
      OP_SHR:  r.value = $signed(a) >>> b[5:0];
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          r.st = ST_DIVZERO;
        end else if (op == OP_DIV) begin
          r.value = ua / ub;
          if (a[63] ^ b[63]) r.value = -r.value;
        end else begin
          r.value = ua % ub;
          if (a[63]) r.value = -r.value;
        end
      end
      OP_LT:   r.value = 64'($signed(a) < $signed(b));
      OP_GT:   r.value = 64'($signed(a) > $signed(b));
      OP_EQ:   r.value = 64'(a == b);
      OP_NE:   r.value = 64'(a != b);
      OP_LE:   r.value = 64'($signed(a) <= $signed(b));
      OP_GE:   r.value = 64'($signed(a) >= $signed(b));
      OP_LAND: r.value = 64'(a != 0 && b != 0);
      OP_LOR:  r.value = 64'(a != 0 || b != 0);
      OP_NEG:  r.value = -a;
      OP_PLUS: r.value = a;
      OP_NOT:  r.value = ~a;
      default: r.st = ST_BADOP;
    endcase
    return r;
  endfunction

  // offers one item until accepted, then queues its expected result
  task automatic send_op(logic [4:0] op, logic [63:0] a, logic [63:0] b);
    s_axis_tdata <= {3'b000, b, a, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    alu_results_q.push_back(alu_compute(op, a, b));
  endtask

  task automatic go_idle(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = MinVal;
      1: v = MaxVal;
      2: v = '0;
      3: v = '1;
      4: v = 64'($urandom_range(0, 8));
      5: v = -64'($urandom_range(1, 8));
      6: v = 64'(32'($urandom));
      default: ;
    endcase
    return v;
  endfunction

  // every opcode, unknown opcodes, divide by zero, min / -1, shift masking
  task automatic test_directed();
    send_op(OP_ADD, MaxVal, 64'd1);
    send_op(OP_SUB, MinVal, 64'd1);
    send_op(OP_MUL, MaxVal, MaxVal);
    send_op(OP_OR, 64'h00ff, '1);
    send_op(OP_XOR, '1, 64'h1234);
    send_op(OP_AND, '1, MinVal);
    send_op(OP_SHL, 64'd1, 64'hffff_ffff_ffff_ff7f);
    send_op(OP_SHR, MinVal, 64'd63);
    send_op(OP_DIV, MinVal, '1);
    send_op(OP_MOD, MinVal, '1);
    send_op(OP_DIV, 64'd7, '0);
    send_op(OP_MOD, -64'd7, '0);
    send_op(OP_DIV, -64'd7, 64'd2);
    send_op(OP_MOD, -64'd7, 64'd2);
    send_op(OP_LT, MinVal, MaxVal);
    send_op(OP_GT, MinVal, MaxVal);
    send_op(OP_EQ, '1, '1);
    send_op(OP_NE, '1, '1);
    send_op(OP_LE, MaxVal, MaxVal);
    send_op(OP_GE, MinVal, MaxVal);
    send_op(OP_LAND, MinVal, '0);
    send_op(OP_LOR, '0, MinVal);
    send_op(OP_NEG, MinVal, MaxVal);
    send_op(OP_PLUS, MinVal, '1);
    send_op(OP_NOT, '0, '1);
    send_op(5'd21, '1, '1);
    send_op(5'd31, '1, '0);
    go_idle(1);
  endtask

  // sink holds off long while the source keeps offering items
  task automatic test_backpressure();
    hold_sink = 1'b1;
    for (int i = 0; i < 200; i++) send_op(5'($urandom_range(0, 20)), rand64(), rand64());
    hold_sink = 1'b0;
    go_idle(1);
  endtask

  // random bursts with random gaps; a few unknown opcodes sprinkled in
  task automatic test_random(int n);
    int burst;
    int sent;
    logic [4:0] op;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < n; i++) begin
        op = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(21, 31))
                                           : 5'($urandom_range(0, 20));
        send_op(op, rand64(), rand64());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 12));
    end
    go_idle(1);
  endtask

  // sink: no stall for a while, then a random pattern; long hold on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_sink && hold_cnt < 400) begin
        hold_cnt++;
        m_axis_tready <= 1'b0;
      end else if (sink_free) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      if (!hold_sink) hold_cnt = 0;
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    alu_res_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (alu_results_q.size() == 0) begin
        $error("unexpected result value=%h status=%0d", m_axis_tdata[63:0],
               m_axis_tdata[65:64]);
        err_cnt++;
      end else begin
        want = alu_results_q.pop_front();
        if (m_axis_tdata[63:0] !== want.value) begin
          $error("result_value expected %h actual %h", want.value, m_axis_tdata[63:0]);
          err_cnt++;
        end
        if (m_axis_tdata[65:64] !== want.st) begin
          $error("status expected %0d actual %0d", want.st, m_axis_tdata[65:64]);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_free = 1'b1;
    test_directed();
    test_random(200);
    sink_free = 1'b0;
    test_backpressure();
    test_random(1200);
    while (alu_results_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (err_cnt == 0 && alu_results_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== signed_int64_alu_top.f =====
+incdir+rtl/core
rtl/core/sia_pkg.sv
rtl/core/sia_front.sv
rtl/core/sia_queue.sv
rtl/core/sia_back.sv
rtl/core/signed_int64_alu_top.sv
tb/sv/tb_signed_int64_alu_top.sv
